FILE: rtl/law_pkg.sv
// ----------------------------------------------------------------------------
// law_pkg
// shared types, cell codes and rule helpers for the walled life grid
// ----------------------------------------------------------------------------
package law_pkg;

    localparam int unsigned DEF_MAX_CELLS = 65536;
    localparam int unsigned DIM_W         = 9;
    localparam int unsigned POS_W         = 8;
    localparam logic [DIM_W-1:0] DIM_MAX  = 9'd256;

    localparam logic [1:0] CELL_DEAD  = 2'd0;
    localparam logic [1:0] CELL_ALIVE = 2'd1;
    localparam logic [1:0] CELL_WALL  = 2'd2;

    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] SURVIVE_MIN = 4'd2;
    localparam logic [3:0] SURVIVE_MAX = 4'd3;

    // neighbour offset codes
    localparam logic [1:0] OFS_MINUS = 2'd0;
    localparam logic [1:0] OFS_ZERO  = 2'd1;
    localparam logic [1:0] OFS_PLUS  = 2'd2;

    localparam logic [3:0] K_CENTRE = 4'd4;
    localparam logic [3:0] K_LAST   = 4'd8;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [1:0]       dx;
        logic [1:0]       dy;
        logic             direct;
    } law_nbr_req_t;

    // step number of the 3x3 window to row/column offsets
    function automatic logic [3:0] law_win_ofs(input logic [3:0] k);
        logic [3:0] r;
        case (k)
            4'd0: r = {OFS_MINUS, OFS_MINUS};
            4'd1: r = {OFS_MINUS, OFS_ZERO};
            4'd2: r = {OFS_MINUS, OFS_PLUS};
            4'd3: r = {OFS_ZERO,  OFS_MINUS};
            4'd4: r = {OFS_ZERO,  OFS_ZERO};
            4'd5: r = {OFS_ZERO,  OFS_PLUS};
            4'd6: r = {OFS_PLUS,  OFS_MINUS};
            4'd7: r = {OFS_PLUS,  OFS_ZERO};
            4'd8: r = {OFS_PLUS,  OFS_PLUS};
            default: r = {OFS_ZERO, OFS_ZERO};
        endcase
        return r;
    endfunction

    function automatic logic [1:0] law_rule(input logic [1:0] c, input logic [3:0] n);
        logic [1:0] r;
        r = c;
        if (c == CELL_DEAD && n == BIRTH_COUNT) r = CELL_ALIVE;
        if (c == CELL_ALIVE && (n < SURVIVE_MIN || n > SURVIVE_MAX)) r = CELL_DEAD;
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] law_dim_clamp(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = 9'd1;
        else if (v > DIM_MAX) r = DIM_MAX;
        return r;
    endfunction

endpackage

FILE: rtl/law_cell_ram.sv
// ----------------------------------------------------------------------------
// law_cell_ram
// single-port-write, single-port-read cell store with registered read data
// ----------------------------------------------------------------------------
module law_cell_ram #(
    parameter int unsigned DEPTH = 65536,
    parameter int unsigned AW    = 16
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [1:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [1:0]    rd_data
);
    logic [1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/law_nbr_addr.sv
// ----------------------------------------------------------------------------
// law_nbr_addr
// wrapped neighbour address unit, one address per cycle, registered
// ----------------------------------------------------------------------------
module law_nbr_addr #(
    parameter int unsigned MAX_CELLS = 65536,
    parameter int unsigned AW        = 16
) (
    input  logic                 aclk,
    input  law_pkg::law_nbr_req_t req,
    input  logic [AW-1:0]        direct_addr,
    input  logic [8:0]           wc,
    input  logic [8:0]           hc,
    output logic [AW-1:0]        addr_reg,
    output logic                 oob_reg
);
    import law_pkg::*;

    localparam int unsigned LW = (AW > 17) ? AW : 17;

    logic [POS_W-1:0] x, y;
    logic [DIM_W-1:0] wm1, hm1;
    logic [16:0]      lin;
    logic [LW-1:0]    lin_ext;
    logic [AW-1:0]    addr_next;
    logic             oob_next;

    always_comb begin
        wm1 = wc - 9'd1;
        hm1 = hc - 9'd1;
        case (req.dx)
            OFS_MINUS: x = (req.col == '0) ? wm1[POS_W-1:0] : req.col - 8'd1;
            OFS_PLUS:  x = ({1'b0, req.col} == wm1) ? '0 : req.col + 8'd1;
            default:   x = req.col;
        endcase
        case (req.dy)
            OFS_MINUS: y = (req.row == '0) ? hm1[POS_W-1:0] : req.row - 8'd1;
            OFS_PLUS:  y = ({1'b0, req.row} == hm1) ? '0 : req.row + 8'd1;
            default:   y = req.row;
        endcase
        lin       = 17'(wc) * 17'(y) + 17'(x);
        lin_ext   = LW'(lin);
        addr_next = req.direct ? direct_addr : lin_ext[AW-1:0];
        // past the end of the store reads as dead
        oob_next  = !req.direct && ({15'b0, lin} >= 32'(MAX_CELLS));
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        oob_reg  <= oob_next;
    end

endmodule

FILE: rtl/life_automaton_with_walls.sv
// ----------------------------------------------------------------------------
// life_automaton_with_walls
// toroidal life grid with wall cells, two banked cell stores
// ----------------------------------------------------------------------------
// usage
//   s_ channel carries one command item: write, read, advance or fill.
//   m_ channel returns exactly one result item per command (read value and
//   index error flag). apb port sets grid width (0x0) and height (0x4).
// operation
//   write: result registered on accept; ready again while the output register is empty or m_tready is high
//   read: one registered store read, then the value goes to the output register
//   fill: one store entry written per cycle over all MAX_CELLS entries
//   advance: per active cell, nine reads through the shared address unit and single
//   read port, the s1 and s2 pipe registers and one write back; a cell beyond the
//   active area only reads its centre and writes it back; over all MAX_CELLS cells
// reset
//   a clearing pass writes dead into every entry of the live bank, with
//   s_tready low; apb writes are taken meanwhile
// stalls
//   s_tready stays low while a command runs or while a result waits on
//   m_tready; results are held in the output register until taken
// ----------------------------------------------------------------------------
module life_automaton_with_walls #(
    parameter int unsigned MAX_CELLS = law_pkg::DEF_MAX_CELLS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // action[1:0], cell_index[17:2], cell_value[19:18]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // read_value[1:0], index_error[2]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import law_pkg::*;

    localparam int unsigned AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int unsigned CW = $clog2(MAX_CELLS + 1);
    localparam int unsigned NW = (CW > 17) ? CW : 17;
    localparam logic [AW-1:0] I_LAST = AW'(MAX_CELLS - 1);

    // command codes
    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_ADVANCE = 2'd2;
    localparam logic [1:0] ACT_FILL    = 2'd3;

    // sequencer states
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_FILL  = 3'd3;
    localparam logic [2:0] ST_ISSUE = 3'd4;
    localparam logic [2:0] ST_WB    = 3'd5;

    // register addresses
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // configuration
    logic [8:0] width_reg, width_next;
    logic [8:0] height_reg, height_next;
    logic [8:0] wc, hc;
    logic [NW-1:0] n_full, n_act;
    logic          cfg_wr;

    // command fields
    logic [1:0]  in_action;
    logic [15:0] in_index;
    logic [1:0]  in_value;
    logic [NW-1:0] in_index_ext;
    logic        in_ok, accept;

    // sequencer
    logic [2:0]    state_reg, state_next;
    logic          sel_reg, sel_next;        // which bank holds the live grid
    logic [AW-1:0] i_reg, i_next;
    logic [7:0]    col_reg, col_next, row_reg, row_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [3:0]    alive_reg, alive_next;
    logic [1:0]    centre_reg, centre_next;
    logic [1:0]    fill_val_reg, fill_val_next;
    logic          evolve;
    logic [3:0]    k_last, k_issue, ofs;
    logic          issue;

    // window pipe
    logic       s1_valid_reg, s2_valid_reg;
    logic [3:0] s1_k_reg, s2_k_reg;
    logic       s2_oob_reg;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_rd_reg, out_rd_next;
    logic       out_err_reg, out_err_next;

    // store ports
    law_nbr_req_t  req;
    logic [AW-1:0] nbr_addr;
    logic          nbr_oob;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [1:0]    wr_data, rd_a, rd_b, rd_cur, new_cell;
    logic          wr_en, wr_bank;

    assign in_action    = s_tdata[1:0];
    assign in_index     = s_tdata[17:2];
    assign in_value     = s_tdata[19:18];
    assign in_index_ext = NW'(in_index);

    // active cell count, limited to the store size
    always_comb begin
        wc     = law_dim_clamp(width_reg);
        hc     = law_dim_clamp(height_reg);
        n_full = NW'(wc) * NW'(hc);
        n_act  = (n_full > NW'(MAX_CELLS)) ? NW'(MAX_CELLS) : n_full;
    end

    assign in_ok = in_index_ext < n_act;

    // apb port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_HEIGHT) ? {23'b0, height_reg} : {23'b0, width_reg};

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr && paddr[2] == REG_WIDTH)  width_next  = pwdata[8:0];
        if (cfg_wr && paddr[2] == REG_HEIGHT) height_next = pwdata[8:0];
    end

    // handshakes
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_err_reg, out_rd_reg};

    // window step control
    assign evolve  = NW'(i_reg) < n_act;
    assign k_last  = evolve ? K_LAST : 4'd0;
    assign k_issue = evolve ? cnt_reg : K_CENTRE;
    assign issue   = (state_reg == ST_ISSUE) && (cnt_reg <= k_last);
    assign ofs     = law_win_ofs(k_issue);

    always_comb begin
        req.col    = col_reg;
        req.row    = row_reg;
        req.dy     = ofs[3:2];
        req.dx     = ofs[1:0];
        req.direct = !evolve;
    end

    law_nbr_addr #(
        .MAX_CELLS (MAX_CELLS),
        .AW        (AW)
    ) u_nbr_addr (
        .aclk        (aclk),
        .req         (req),
        .direct_addr (i_reg),
        .wc          (wc),
        .hc          (hc),
        .addr_reg    (nbr_addr),
        .oob_reg     (nbr_oob)
    );

    // the two banks, live one chosen by sel_reg
    law_cell_ram #(.DEPTH(MAX_CELLS), .AW(AW)) u_bank_a (
        .aclk    (aclk),
        .wr_en   (wr_en && !wr_bank),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_a)
    );

    law_cell_ram #(.DEPTH(MAX_CELLS), .AW(AW)) u_bank_b (
        .aclk    (aclk),
        .wr_en   (wr_en && wr_bank),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_b)
    );

    assign rd_cur   = sel_reg ? rd_b : rd_a;
    assign rd_addr  = (state_reg == ST_IDLE) ? in_index_ext[AW-1:0] : nbr_addr;
    assign new_cell = evolve ? ((centre_reg == CELL_WALL) ? centre_reg :
                                law_rule(centre_reg, alive_reg)) : centre_reg;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        i_next         = i_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        alive_next     = alive_reg;
        centre_next    = centre_reg;
        fill_val_next  = fill_val_reg;
        out_valid_next = out_valid_reg;
        out_rd_next    = out_rd_reg;
        out_err_next   = out_err_reg;
        wr_en          = 1'b0;
        wr_bank        = sel_reg;
        wr_addr        = i_reg;
        wr_data        = fill_val_reg;

        if (m_tvalid && m_tready) out_valid_next = 1'b0;

        case (state_reg)
            ST_CLEAR, ST_FILL: begin
                // sweep the live bank, one entry a cycle
                wr_en  = 1'b1;
                i_next = i_reg + 1'b1;
                if (i_reg == I_LAST) begin
                    i_next     = '0;
                    state_next = ST_IDLE;
                    if (state_reg == ST_FILL) begin
                        out_valid_next = 1'b1;
                        out_rd_next    = CELL_DEAD;
                        out_err_next   = 1'b0;
                    end
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (in_action)
                        ACT_WRITE: begin
                            wr_en          = in_ok;
                            wr_addr        = in_index_ext[AW-1:0];
                            wr_data        = in_value;
                            out_valid_next = 1'b1;
                            out_rd_next    = CELL_DEAD;
                            out_err_next   = !in_ok;
                        end
                        ACT_READ: begin
                            out_err_next = !in_ok;
                            state_next   = ST_READ;
                        end
                        ACT_ADVANCE: begin
                            i_next     = '0;
                            col_next   = '0;
                            row_next   = '0;
                            cnt_next   = '0;
                            alive_next = '0;
                            state_next = ST_ISSUE;
                        end
                        ACT_FILL: begin
                            i_next        = '0;
                            fill_val_next = in_value;
                            state_next    = ST_FILL;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                out_valid_next = 1'b1;
                out_rd_next    = out_err_reg ? CELL_DEAD : rd_cur;
                state_next     = ST_IDLE;
            end
            ST_ISSUE: begin
                if (issue) cnt_next = cnt_reg + 4'd1;
                if (s2_valid_reg) begin
                    if (s2_k_reg == K_CENTRE) begin
                        centre_next = rd_cur;
                    end else if (rd_cur == CELL_ALIVE && !s2_oob_reg) begin
                        alive_next = alive_reg + 4'd1;
                    end
                    // a cell beyond the active area only fetches its centre
                    if (!evolve || s2_k_reg == K_LAST) state_next = ST_WB;
                end
            end
            ST_WB: begin
                // new generation goes to the idle bank
                wr_en      = 1'b1;
                wr_bank    = !sel_reg;
                wr_data    = new_cell;
                cnt_next   = '0;
                alive_next = '0;
                state_next = ST_ISSUE;
                i_next     = i_reg + 1'b1;
                if (evolve) begin
                    if ({1'b0, col_reg} == wc - 9'd1) begin
                        col_next = '0;
                        row_next = row_reg + 8'd1;
                    end else begin
                        col_next = col_reg + 8'd1;
                    end
                end
                if (i_reg == I_LAST) begin
                    i_next         = '0;
                    sel_next       = !sel_reg;
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_rd_next    = CELL_DEAD;
                    out_err_next   = 1'b0;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            sel_reg       <= 1'b0;
            i_reg         <= '0;
            fill_val_reg  <= CELL_DEAD;
            out_valid_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            width_reg     <= DIM_MAX;
            height_reg    <= DIM_MAX;
        end else begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            i_reg         <= i_next;
            fill_val_reg  <= fill_val_next;
            out_valid_reg <= out_valid_next;
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            width_reg     <= width_next;
            height_reg    <= height_next;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg     <= col_next;
        row_reg     <= row_next;
        cnt_reg     <= cnt_next;
        alive_reg   <= alive_next;
        centre_reg  <= centre_next;
        out_rd_reg  <= out_rd_next;
        out_err_reg <= out_err_next;
        s1_k_reg    <= k_issue;
        s2_k_reg    <= s1_k_reg;
        s2_oob_reg  <= nbr_oob;
    end

endmodule
